>>> src/arct_pkg.sv
`timescale 1ns / 1ps
package arct_pkg;

  localparam int unsigned MaxRanges = 128;
  localparam int unsigned AngleBits = 16;
  localparam int unsigned CntW      = $clog2(MaxRanges + 1);
  localparam int unsigned AddrW     = $clog2(MaxRanges);
  localparam int unsigned EntryW    = 2 * AngleBits;
  localparam logic [AngleBits-1:0] AngleMax = {AngleBits{1'b1}};

  localparam logic [1:0] CmdClear      = 2'd0;
  localparam logic [1:0] CmdAdd        = 2'd1;
  localparam logic [1:0] CmdQueryRange = 2'd2;
  localparam logic [1:0] CmdQueryAngle = 2'd3;

  typedef struct packed {
    logic [1:0]           cmd;
    logic [AngleBits-1:0] start_angle;
    logic [AngleBits-1:0] end_angle;
  } in_t;

  typedef struct packed {
    logic       visible;
    logic       overflow;
    logic [7:0] entries_used;
  } out_t;

endpackage

>>> src/arct_ram.sv
`timescale 1ns / 1ps
module arct_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/angle_range_clip_table.sv
`timescale 1ns / 1ps
// Angle range clip table: a sorted list of disjoint closed angle ranges
// kept in one simple dual-port RAM (one entry = start and end angle).
// Input channel in_valid_i/in_ready_o carries one command item: clear,
// add range, query range or query angle. Output channel
// out_valid_o/out_ready_i returns one result item per command: visible
// flag, overflow flag and the entry count after the command.
// One command is worked at a time; in_ready_o is high while idle, also
// when a finished result still sits in the output register.
// Every pass over the table handles one entry at a time: RAM read, then
// evaluate and write back. A query is one pass. An add part runs up to
// four passes (contain check, swallow compaction, overlap scan, then an
// insert shift or a fuse shift); a wrapped add does two parts. The single
// RAM read port sets the pace.
// Reset empties the table (count to zero); RAM contents are not cleared
// since entries past the count are never read. When the receiver stalls
// the block holds its result and does not finish the next command until
// the output register frees up.
module angle_range_clip_table (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  arct_pkg::in_t   in_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output arct_pkg::out_t  out_o
);

  localparam int unsigned AB = arct_pkg::AngleBits;
  localparam int unsigned CW = arct_pkg::CntW;
  localparam int unsigned AW = arct_pkg::AddrW;

  typedef enum logic [3:0] {
    StIdle, StChkRd, StChkEv, StRmvRd, StRmvEv, StOvlRd, StOvlEv,
    StNxtEv, StShdRd, StShdEv, StInsRd, StInsEv, StFin
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          out_valid_q, out_valid_d;
  arct_pkg::out_t out_q, out_d;

  logic [1:0]    cmd_q, cmd_d;
  logic [AB-1:0] ps_q, ps_d, pe_q, pe_d, qs_q, qs_d, qe_q, qe_d, e_q, e_d;
  logic [AB-1:0] keep_q, keep_d;
  logic [CW-1:0] idx_q, idx_d, wr_q, wr_d, pos_q, pos_d, ins_q, ins_d;
  logic          p2_q, p2_d, ovf_q, ovf_d, hit0_q, hit0_d, hit1_q, hit1_d;
  logic          have_pos_q, have_pos_d;

  // RAM port
  logic                        we;
  logic [AW-1:0]               waddr, raddr;
  logic [arct_pkg::EntryW-1:0] wdata, rdata;
  logic [AB-1:0]               ent_st, ent_en;
  logic                        done_part, wrap, contains;

  arct_ram #(
    .Width (arct_pkg::EntryW),
    .Depth (arct_pkg::MaxRanges)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign ent_st   = rdata[2*AB-1:AB];
  assign ent_en   = rdata[AB-1:0];
  assign wrap     = in_i.start_angle > in_i.end_angle;
  assign contains = (ps_q >= ent_st) && (pe_q <= ent_en);

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    cmd_d       = cmd_q;
    ps_d        = ps_q;
    pe_d        = pe_q;
    qs_d        = qs_q;
    qe_d        = qe_q;
    e_d         = e_q;
    keep_d      = keep_q;
    idx_d       = idx_q;
    wr_d        = wr_q;
    pos_d       = pos_q;
    ins_d       = ins_q;
    p2_d        = p2_q;
    ovf_d       = ovf_q;
    hit0_d      = hit0_q;
    hit1_d      = hit1_q;
    have_pos_d  = have_pos_q;
    we          = 1'b0;
    waddr       = idx_q[AW-1:0];
    wdata       = {ps_q, ent_en};
    raddr       = idx_q[AW-1:0];
    done_part   = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_d  = in_i.cmd;
          e_d    = in_i.end_angle;
          ovf_d  = 1'b0;
          hit0_d = 1'b0;
          hit1_d = 1'b0;
          idx_d  = '0;
          p2_d   = 1'b0;
          ps_d   = in_i.start_angle;
          pe_d   = wrap ? arct_pkg::AngleMax : in_i.end_angle;
          qs_d   = wrap ? '0 : in_i.start_angle;
          qe_d   = in_i.end_angle;
          if (in_i.cmd == arct_pkg::CmdClear) begin
            cnt_d   = '0;
            state_d = StFin;
          end else begin
            p2_d    = (in_i.cmd == arct_pkg::CmdAdd) && wrap;
            state_d = StChkRd;
          end
        end
      end
      StChkRd: begin
        if (idx_q >= cnt_q) begin
          if (cmd_q == arct_pkg::CmdAdd) begin
            idx_d   = '0;
            wr_d    = '0;
            state_d = StRmvRd;
          end else begin
            state_d = StFin;
          end
        end else begin
          state_d = StChkEv;
        end
      end
      StChkEv: begin
        idx_d   = idx_q + CW'(1);
        state_d = StChkRd;
        case (cmd_q)
          arct_pkg::CmdAdd: begin
            if (contains) done_part = 1'b1;
          end
          arct_pkg::CmdQueryRange: begin
            if (contains) hit0_d = 1'b1;
            if (qs_q >= ent_st && qe_q <= ent_en) hit1_d = 1'b1;
          end
          default: begin
            if (ps_q > ent_st && ps_q < ent_en) hit0_d = 1'b1;
          end
        endcase
      end
      // drop entries swallowed by the part, compacting in place
      StRmvRd: begin
        if (idx_q >= cnt_q) begin
          cnt_d      = wr_q;
          idx_d      = '0;
          have_pos_d = 1'b0;
          pos_d      = '0;
          state_d    = StOvlRd;
        end else begin
          state_d = StRmvEv;
        end
      end
      StRmvEv: begin
        if (!(ent_st >= ps_q && ent_en <= pe_q)) begin
          we    = 1'b1;
          waddr = wr_q[AW-1:0];
          wdata = rdata;
          wr_d  = wr_q + CW'(1);
        end
        idx_d   = idx_q + CW'(1);
        state_d = StRmvRd;
      end
      StOvlRd: begin
        if (idx_q >= cnt_q) begin
          if (cnt_q == CW'(arct_pkg::MaxRanges)) begin
            ovf_d     = 1'b1;
            done_part = 1'b1;
          end else begin
            ins_d   = have_pos_q ? pos_q + CW'(1) : '0;
            state_d = StInsRd;
          end
        end else begin
          state_d = StOvlEv;
        end
      end
      StOvlEv: begin
        raddr  = AW'(idx_q + CW'(1));
        keep_d = ent_st;
        if (ent_st < pe_q) begin
          have_pos_d = 1'b1;
          pos_d      = idx_q;
        end
        if (ent_st >= ps_q && ent_st <= pe_q) begin
          we        = 1'b1;
          wdata     = {ps_q, ent_en};
          done_part = 1'b1;
        end else if (ent_en >= ps_q && ent_en <= pe_q) begin
          if (idx_q + CW'(1) < cnt_q) begin
            state_d = StNxtEv;
          end else begin
            we        = 1'b1;
            wdata     = {ent_st, pe_q};
            done_part = 1'b1;
          end
        end else begin
          idx_d   = idx_q + CW'(1);
          state_d = StOvlRd;
        end
      end
      // rdata holds the entry after the one whose end was hit
      StNxtEv: begin
        we = 1'b1;
        if (ent_st <= pe_q) begin
          wdata   = {keep_q, ent_en};
          idx_d   = idx_q + CW'(2);
          wr_d    = idx_q + CW'(1);
          state_d = StShdRd;
        end else begin
          wdata     = {keep_q, pe_q};
          done_part = 1'b1;
        end
      end
      StShdRd: begin
        if (idx_q >= cnt_q) begin
          cnt_d     = cnt_q - CW'(1);
          done_part = 1'b1;
        end else begin
          state_d = StShdEv;
        end
      end
      StShdEv: begin
        we      = 1'b1;
        waddr   = wr_q[AW-1:0];
        wdata   = rdata;
        wr_d    = wr_q + CW'(1);
        idx_d   = idx_q + CW'(1);
        state_d = StShdRd;
      end
      // shift the tail up one slot, top down, then drop in the part
      StInsRd: begin
        if (idx_q == ins_q) begin
          we        = 1'b1;
          waddr     = ins_q[AW-1:0];
          wdata     = {ps_q, pe_q};
          cnt_d     = cnt_q + CW'(1);
          done_part = 1'b1;
        end else begin
          raddr   = AW'(idx_q - CW'(1));
          state_d = StInsEv;
        end
      end
      StInsEv: begin
        we      = 1'b1;
        wdata   = rdata;
        idx_d   = idx_q - CW'(1);
        state_d = StInsRd;
      end
      StFin: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d        = 1'b1;
          out_d.overflow     = ovf_q;
          out_d.entries_used = 8'(cnt_q);
          case (cmd_q)
            arct_pkg::CmdQueryRange: out_d.visible = !(hit0_q && hit1_q);
            arct_pkg::CmdQueryAngle: out_d.visible = !hit0_q;
            default:                 out_d.visible = 1'b0;
          endcase
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    // second part of a wrapped add: 0..end
    if (done_part) begin
      if (p2_q) begin
        ps_d    = '0;
        pe_d    = e_q;
        p2_d    = 1'b0;
        idx_d   = '0;
        state_d = StChkRd;
      end else begin
        state_d = StFin;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q      <= out_d;
    cmd_q      <= cmd_d;
    ps_q       <= ps_d;
    pe_q       <= pe_d;
    qs_q       <= qs_d;
    qe_q       <= qe_d;
    e_q        <= e_d;
    keep_q     <= keep_d;
    idx_q      <= idx_d;
    wr_q       <= wr_d;
    pos_q      <= pos_d;
    ins_q      <= ins_d;
    p2_q       <= p2_d;
    ovf_q      <= ovf_d;
    hit0_q     <= hit0_d;
    hit1_q     <= hit1_d;
    have_pos_q <= have_pos_d;
  end

endmodule

>>> tb/tb_angle_range_clip_table.sv
`timescale 1ns / 1ps
module tb_angle_range_clip_table;

  localparam int unsigned NumRandom = 1300;
  localparam int unsigned IdleLimit = 40000;

  logic           clk_i;
  logic           rst_ni;
  logic           in_valid_i;
  logic           in_ready_o;
  arct_pkg::in_t  in_i;
  logic           out_valid_o;
  logic           out_ready_i;
  arct_pkg::out_t out_o;

  angle_range_clip_table uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

  // Shadow copy of the table, kept sorted by start angle.
  logic [arct_pkg::AngleBits-1:0] tbl_lo [arct_pkg::MaxRanges];
  logic [arct_pkg::AngleBits-1:0] tbl_hi [arct_pkg::MaxRanges];
  int unsigned                    tbl_n;

  // Results still owed by the block, oldest first.
  arct_pkg::out_t pending_results[$];

  int unsigned errors;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned overflows_seen;
  int unsigned idle_cycles;
  bit          long_stall;

  // Directed rows: typed expectation is used only where has_exp is set.
  typedef struct {
    logic [1:0]                     cmd;
    logic [arct_pkg::AngleBits-1:0] sa;
    logic [arct_pkg::AngleBits-1:0] ea;
    bit                             has_exp;
    arct_pkg::out_t                 exp;
  } row_t;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void tbl_remove(input int unsigned idx);
    for (int unsigned k = idx; k + 1 < tbl_n; k++) begin
      tbl_lo[k] = tbl_lo[k+1];
      tbl_hi[k] = tbl_hi[k+1];
    end
    tbl_n--;
  endfunction

  function automatic void tbl_insert(input int unsigned idx,
                                     input logic [arct_pkg::AngleBits-1:0] lo,
                                     input logic [arct_pkg::AngleBits-1:0] hi);
    for (int unsigned k = tbl_n; k > idx; k--) begin
      tbl_lo[k] = tbl_lo[k-1];
      tbl_hi[k] = tbl_hi[k-1];
    end
    tbl_lo[idx] = lo;
    tbl_hi[idx] = hi;
    tbl_n++;
  endfunction

  // Merge one non-wrapping part; returns 1 when it needed a slot in a full table.
  function automatic bit merge_part(input logic [arct_pkg::AngleBits-1:0] lo,
                                    input logic [arct_pkg::AngleBits-1:0] hi);
    int unsigned i;
    int unsigned pos;
    bit          have_pos;
    pos = 0;
    have_pos = 1'b0;
    if (tbl_n == 0) begin
      tbl_insert(0, lo, hi);
      return 1'b0;
    end
    for (i = 0; i < tbl_n; i++)
      if (lo >= tbl_lo[i] && hi <= tbl_hi[i]) return 1'b0;
    i = 0;
    while (i < tbl_n) begin
      if (tbl_lo[i] >= lo && tbl_hi[i] <= hi) tbl_remove(i);
      else i++;
    end
    for (i = 0; i < tbl_n; i++) begin
      if (tbl_lo[i] < hi) begin
        have_pos = 1'b1;
        pos = i;
      end
      if (tbl_lo[i] >= lo && tbl_lo[i] <= hi) begin
        tbl_lo[i] = lo;
        return 1'b0;
      end
      if (tbl_hi[i] >= lo && tbl_hi[i] <= hi) begin
        // Extending the end can reach the next entry; fuse the two.
        if (i + 1 < tbl_n && tbl_lo[i+1] <= hi) begin
          tbl_hi[i] = tbl_hi[i+1];
          tbl_remove(i + 1);
        end else begin
          tbl_hi[i] = hi;
        end
        return 1'b0;
      end
    end
    if (tbl_n >= arct_pkg::MaxRanges) return 1'b1;
    tbl_insert(have_pos ? pos + 1 : 0, lo, hi);
    return 1'b0;
  endfunction

  function automatic bit part_open(input logic [arct_pkg::AngleBits-1:0] lo,
                                   input logic [arct_pkg::AngleBits-1:0] hi);
    for (int unsigned i = 0; i < tbl_n; i++)
      if (lo >= tbl_lo[i] && hi <= tbl_hi[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit angle_open(input logic [arct_pkg::AngleBits-1:0] a);
    for (int unsigned i = 0; i < tbl_n; i++)
      if (a > tbl_lo[i] && a < tbl_hi[i]) return 1'b0;
    return 1'b1;
  endfunction

  // Apply one command item to the shadow table and return its result.
  function automatic arct_pkg::out_t clip_predict(input arct_pkg::in_t cmd_item);
    arct_pkg::out_t r;
    bit             ovf_a;
    bit             ovf_b;
    r = '0;
    case (cmd_item.cmd)
      arct_pkg::CmdClear: begin
        tbl_n = 0;
      end
      arct_pkg::CmdAdd: begin
        if (cmd_item.start_angle > cmd_item.end_angle) begin
          // Wrapped: high part first, then the low part even if the first overflowed.
          ovf_a = merge_part(cmd_item.start_angle, arct_pkg::AngleMax);
          ovf_b = merge_part('0, cmd_item.end_angle);
          r.overflow = ovf_a | ovf_b;
        end else begin
          r.overflow = merge_part(cmd_item.start_angle, cmd_item.end_angle);
        end
      end
      arct_pkg::CmdQueryRange: begin
        if (cmd_item.start_angle > cmd_item.end_angle)
          r.visible = part_open(cmd_item.start_angle, arct_pkg::AngleMax) |
                      part_open('0, cmd_item.end_angle);
        else
          r.visible = part_open(cmd_item.start_angle, cmd_item.end_angle);
      end
      default: begin
        r.visible = angle_open(cmd_item.start_angle);
      end
    endcase
    r.entries_used = 8'(tbl_n);
    return r;
  endfunction

  // Drive one item at the falling edge and hold it until accepted.
  task automatic send_item(input arct_pkg::in_t cmd_item, input bit has_exp,
                           input arct_pkg::out_t exp);
    arct_pkg::out_t pred;
    @(negedge clk_i);
    in_i       <= cmd_item;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pred = clip_predict(cmd_item);
    if (has_exp && pred !== exp) begin
      $display("%0t predictor disagrees with typed row: expected %p, predicted %p",
               $time, exp, pred);
      errors++;
    end
    pending_results.push_back(has_exp ? exp : pred);
    items_sent++;
  endtask

  task automatic gap_cycles(input int unsigned n);
    if (n == 0) return;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // Random command item (clear, add or query) with mostly narrow ranges so the table grows, merges and fills.
  function automatic arct_pkg::in_t rand_item(input int unsigned mode);
    arct_pkg::in_t it;
    int unsigned   w;
    it.cmd = 2'($urandom_range(0, 99) < 1 ? arct_pkg::CmdClear :
                $urandom_range(0, 99) < 55 ? arct_pkg::CmdAdd :
                $urandom_range(0, 1) ? arct_pkg::CmdQueryRange : arct_pkg::CmdQueryAngle);
    it.start_angle = 16'($urandom);
    if (mode == 0) begin
      // Noise: full random range, wraps included.
      it.end_angle = 16'($urandom);
    end else begin
      w = (mode == 1) ? $urandom_range(0, 300) : $urandom_range(0, 4000);
      it.end_angle = it.start_angle + 16'(w);
    end
    return it;
  endfunction

  // Receiver: random stall pattern, plus one long hold-off mid-run.
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_stall) begin
        out_ready_i <= 1'b0;
        repeat (3000) @(negedge clk_i);
        long_stall = 1'b0;
      end
      case ($urandom_range(0, 3))
        0: out_ready_i <= 1'b0;
        default: out_ready_i <= 1'b1;
      endcase
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    arct_pkg::out_t exp;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %p", $time, out_o);
        errors++;
      end else begin
        exp = pending_results.pop_front();
        if (out_o.visible !== exp.visible) begin
          $display("%0t visible mismatch: expected %b, actual %b",
                   $time, exp.visible, out_o.visible);
          errors++;
        end
        if (out_o.overflow !== exp.overflow) begin
          $display("%0t overflow mismatch: expected %b, actual %b",
                   $time, exp.overflow, out_o.overflow);
          errors++;
        end
        if (out_o.entries_used !== exp.entries_used) begin
          $display("%0t entries_used mismatch: expected %0d, actual %0d",
                   $time, exp.entries_used, out_o.entries_used);
          errors++;
        end
        if (exp.overflow) overflows_seen++;
      end
    end
  end

  // Watchdog: cycles without any handshake.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("%0t watchdog: no handshake for %0d cycles", $time, idle_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    row_t           rows[$];
    arct_pkg::out_t none;
    arct_pkg::in_t  it;
    int unsigned    burst;
    int unsigned    mode;
    int unsigned    wait_n;
    none = '0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_i = '0;
    errors = 0;
    items_sent = 0;
    results_seen = 0;
    overflows_seen = 0;
    idle_cycles = 0;
    long_stall = 1'b0;
    tbl_n = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: empty table, extremes, wrap, contain, swallow, fuse, endpoints.
    rows.push_back('{arct_pkg::CmdQueryRange, 16'h0000, 16'hFFFF, 1, '{1'b1, 1'b0, 8'd0}});
    rows.push_back('{arct_pkg::CmdQueryAngle, 16'h8000, 16'h0000, 1, '{1'b1, 1'b0, 8'd0}});
    rows.push_back('{arct_pkg::CmdAdd, 16'h1000, 16'h2000, 1, '{1'b0, 1'b0, 8'd1}});
    rows.push_back('{arct_pkg::CmdQueryAngle, 16'h1000, 16'h0000, 1, '{1'b1, 1'b0, 8'd1}});
    rows.push_back('{arct_pkg::CmdQueryAngle, 16'h1001, 16'h0000, 1, '{1'b0, 1'b0, 8'd1}});
    rows.push_back('{arct_pkg::CmdQueryAngle, 16'h2000, 16'hFFFF, 1, '{1'b1, 1'b0, 8'd1}});
    rows.push_back('{arct_pkg::CmdAdd, 16'h1200, 16'h1800, 0, none});
    rows.push_back('{arct_pkg::CmdAdd, 16'h3000, 16'h4000, 0, none});
    rows.push_back('{arct_pkg::CmdAdd, 16'h2000, 16'h3000, 0, none});
    rows.push_back('{arct_pkg::CmdAdd, 16'h0800, 16'h1000, 0, none});
    rows.push_back('{arct_pkg::CmdAdd, 16'h5000, 16'h5100, 0, none});
    rows.push_back('{arct_pkg::CmdAdd, 16'h4F00, 16'h6000, 0, none});
    rows.push_back('{arct_pkg::CmdQueryRange, 16'h0800, 16'h4000, 0, none});
    rows.push_back('{arct_pkg::CmdAdd, 16'hF000, 16'h0100, 0, none});
    rows.push_back('{arct_pkg::CmdQueryRange, 16'hF800, 16'h0080, 0, none});
    rows.push_back('{arct_pkg::CmdQueryRange, 16'hEFFF, 16'h0080, 0, none});
    rows.push_back('{arct_pkg::CmdAdd, 16'h0000, 16'hFFFF, 0, none});
    rows.push_back('{arct_pkg::CmdQueryRange, 16'h0000, 16'hFFFF, 0, none});
    rows.push_back('{arct_pkg::CmdClear, 16'hFFFF, 16'hFFFF, 1, '{1'b0, 1'b0, 8'd0}});
    rows.push_back('{arct_pkg::CmdAdd, 16'hFFFF, 16'hFFFF, 1, '{1'b0, 1'b0, 8'd1}});
    rows.push_back('{arct_pkg::CmdAdd, 16'h0000, 16'h0000, 1, '{1'b0, 1'b0, 8'd2}});
    rows.push_back('{arct_pkg::CmdQueryRange, 16'hFFFF, 16'h0000, 0, none});
    rows.push_back('{arct_pkg::CmdClear, 16'h0000, 16'h0000, 1, '{1'b0, 1'b0, 8'd0}});
    foreach (rows[k]) begin
      it.cmd = rows[k].cmd;
      it.start_angle = rows[k].sa;
      it.end_angle = rows[k].ea;
      send_item(it, rows[k].has_exp, rows[k].exp);
    end

    // Fill the table to overflow: disjoint short ranges spaced apart, two past full, then one wrapped add.
    for (int unsigned k = 0; k <= arct_pkg::MaxRanges + 1; k++) begin
      it.cmd = arct_pkg::CmdAdd;
      it.start_angle = 16'(k * 400 + 10);
      it.end_angle = 16'(k * 400 + 12);
      send_item(it, 1'b0, none);
      if (k == arct_pkg::MaxRanges / 2) long_stall = 1'b1;
    end
    it.cmd = arct_pkg::CmdAdd;
    it.start_angle = 16'hFFF0;
    it.end_angle = 16'h0002;
    send_item(it, 1'b0, none);

    // Random part in bursts with gaps.
    while (items_sent < NumRandom) begin
      burst = $urandom_range(1, 40);
      mode = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 2);
      for (int unsigned k = 0; k < burst; k++)
        send_item(rand_item(mode), 1'b0, none);
      gap_cycles($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30));
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    wait_n = 0;
    while (pending_results.size() != 0 && wait_n < 2000000) begin
      @(posedge clk_i);
      wait_n++;
    end
    repeat (20) @(posedge clk_i);
    $display("covered %0d items, %0d results, %0d overflow results, long receiver stall",
             items_sent, results_seen, overflows_seen);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d errors, %0d results missing", errors, pending_results.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> files.f
src/arct_pkg.sv
src/arct_ram.sv
src/angle_range_clip_table.sv
tb/tb_angle_range_clip_table.sv
